// ----- hdl/eecu_pkg.sv -----
// Package for the export entry checker: widths, status and kind codes,
// register indexes, the result type and the status helper functions.
// No dependencies.
package eecu_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned STATUS_W = 4;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned NUM_REGS = 4;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_FUNC_LIMIT   = 2'd0;
    localparam logic [1:0] REG_TABLE_LIMIT  = 2'd1;
    localparam logic [1:0] REG_MEM_LIMIT    = 2'd2;
    localparam logic [1:0] REG_GLOBAL_LIMIT = 2'd3;

    // Descriptor kinds
    localparam logic [KIND_W-1:0] KIND_FUNC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TABLE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MEM    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_GLOBAL = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 4'd0;
    localparam logic [STATUS_W-1:0] ST_NAME_LEB     = 4'd1;
    localparam logic [STATUS_W-1:0] ST_FUNC_LEB     = 4'd2;
    localparam logic [STATUS_W-1:0] ST_FUNC_RANGE   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_TABLE_LEB    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_TABLE_RANGE  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_MEM_LEB      = 4'd6;
    localparam logic [STATUS_W-1:0] ST_MEM_RANGE    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_GLOBAL_LEB   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_GLOBAL_RANGE = 4'd9;
    localparam logic [STATUS_W-1:0] ST_BAD_KIND     = 4'd10;

    typedef logic [NUM_REGS-1:0][DATA_W-1:0] t_limits;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KIND_W-1:0]   kind;
        logic [DATA_W-1:0]   index_value;
    } t_result;

    function automatic logic [STATUS_W-1:0] leb_bad_code(input logic [KIND_W-1:0] kind);
        logic [STATUS_W-1:0] code;
        unique case (kind)
            KIND_FUNC:  code = ST_FUNC_LEB;
            KIND_TABLE: code = ST_TABLE_LEB;
            KIND_MEM:   code = ST_MEM_LEB;
            default:    code = ST_GLOBAL_LEB;
        endcase
        return code;
    endfunction

    function automatic logic [STATUS_W-1:0] range_code(input logic [KIND_W-1:0] kind);
        logic [STATUS_W-1:0] code;
        unique case (kind)
            KIND_FUNC:  code = ST_FUNC_RANGE;
            KIND_TABLE: code = ST_TABLE_RANGE;
            KIND_MEM:   code = ST_MEM_RANGE;
            default:    code = ST_GLOBAL_RANGE;
        endcase
        return code;
    endfunction

endpackage

// ----- hdl/eecu_if.sv -----
// Stream interfaces of the export entry checker: byte input and result output.
// Depends on eecu_pkg.
interface eecu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       entry_start;

    modport source (output valid, output data_byte, output entry_start, input ready);
    modport sink   (input valid, input data_byte, input entry_start, output ready);
endinterface

interface eecu_result_if;
    import eecu_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KIND_W-1:0]   export_kind;
    logic [DATA_W-1:0]   index_value;

    modport source (output valid, output status, output export_kind, output index_value,
                    input ready);
    modport sink   (input valid, input status, input export_kind, input index_value,
                    output ready);
endinterface

// ----- hdl/eecu_cfg_regs.sv -----
// APB-style register block holding the four index limits.
// Depends on eecu_pkg.
module eecu_cfg_regs
    import eecu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_limits           o_limits
);

    t_limits    r_limits;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_FUNC_LIMIT:   r_limits[REG_FUNC_LIMIT]   <= pwdata;
                REG_TABLE_LIMIT:  r_limits[REG_TABLE_LIMIT]  <= pwdata;
                REG_MEM_LIMIT:    r_limits[REG_MEM_LIMIT]    <= pwdata;
                REG_GLOBAL_LIMIT: r_limits[REG_GLOBAL_LIMIT] <= pwdata;
                default:          r_limits <= r_limits;
            endcase
        end
    end

    assign prdata   = r_limits[reg_idx];
    assign o_limits = r_limits;

endmodule

// ----- hdl/eecu_parser.sv -----
// Input register and single-pass entry parser: LEB128 name length, name skip,
// kind byte, LEB128 index and limit check. Depends on eecu_pkg.
module eecu_parser
    import eecu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_entry_start,
    output logic       o_in_ready,
    input  logic       i_take_ok,
    input  t_limits    i_limits,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_NAME  = 3'd1;
    localparam logic [2:0] PH_SKIP  = 3'd2;
    localparam logic [2:0] PH_KIND  = 3'd3;
    localparam logic [2:0] PH_INDEX = 3'd4;

    logic              r_in_valid, n_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_start;
    logic [2:0]        r_phase, n_phase;
    logic [DATA_W-1:0] r_leb, n_leb;
    logic [2:0]        r_cnt, n_cnt;
    logic [DATA_W-1:0] r_skip, n_skip;
    logic [KIND_W-1:0] r_kind, n_kind;

    logic              adv;
    logic [2:0]        e_phase;
    logic [DATA_W-1:0] e_leb;
    logic [2:0]        e_cnt;
    logic [DATA_W-1:0] e_skip;
    logic [KIND_W-1:0] e_kind;
    logic [DATA_W-1:0] shifted;
    logic [DATA_W-1:0] leb_val;
    logic              leb_bad, leb_done;
    logic [DATA_W-1:0] limit;

    assign adv        = r_in_valid && i_take_ok;
    assign o_in_ready = !r_in_valid || i_take_ok;

    // start mark restarts the parser on this very byte
    assign e_phase = r_in_start ? PH_NAME : r_phase;
    assign e_leb   = r_in_start ? '0 : r_leb;
    assign e_cnt   = r_in_start ? '0 : r_cnt;
    assign e_skip  = r_in_start ? '0 : r_skip;
    assign e_kind  = r_in_start ? '0 : r_kind;

    always_comb begin
        unique case (e_cnt[1:0])
            2'd0:    shifted = {25'b0, r_in_byte[6:0]};
            2'd1:    shifted = {18'b0, r_in_byte[6:0], 7'b0};
            2'd2:    shifted = {11'b0, r_in_byte[6:0], 14'b0};
            default: shifted = {4'b0, r_in_byte[6:0], 21'b0};
        endcase
    end

    // fifth byte: only the low four bits may carry payload
    assign leb_val  = e_leb | (e_cnt[2] ? {r_in_byte[3:0], 28'b0} : shifted);
    assign leb_bad  = e_cnt[2] && (r_in_byte[7:4] != 4'b0);
    assign leb_done = e_cnt[2] ? !leb_bad : !r_in_byte[7];
    assign limit    = i_limits[e_kind];

    always_comb begin
        n_in_valid  = r_in_valid;
        n_phase     = r_phase;
        n_leb       = r_leb;
        n_cnt       = r_cnt;
        n_skip      = r_skip;
        n_kind      = r_kind;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
        end else if (adv) begin
            n_in_valid = 1'b0;
        end

        if (adv) begin
            n_phase = e_phase;
            n_leb   = e_leb;
            n_cnt   = e_cnt;
            n_skip  = e_skip;
            n_kind  = e_kind;
            unique case (e_phase)
                PH_NAME: begin
                    if (leb_bad) begin
                        o_res_valid = 1'b1;
                        o_res       = '{status: ST_NAME_LEB, kind: '0, index_value: '0};
                        n_phase     = PH_IDLE;
                        n_leb       = '0;
                        n_cnt       = '0;
                    end else if (leb_done) begin
                        n_skip  = leb_val;
                        n_leb   = '0;
                        n_cnt   = '0;
                        n_phase = (leb_val == '0) ? PH_KIND : PH_SKIP;
                    end else begin
                        n_leb = leb_val;
                        n_cnt = e_cnt + 3'd1;
                    end
                end
                PH_SKIP: begin
                    n_skip = e_skip - 32'd1;
                    if (e_skip == 32'd1) begin
                        n_phase = PH_KIND;
                    end
                end
                PH_KIND: begin
                    if (r_in_byte > 8'd3) begin
                        o_res_valid = 1'b1;
                        o_res       = '{status: ST_BAD_KIND, kind: '0, index_value: '0};
                        n_phase     = PH_IDLE;
                        n_leb       = '0;
                        n_cnt       = '0;
                    end else begin
                        n_kind  = r_in_byte[1:0];
                        n_leb   = '0;
                        n_cnt   = '0;
                        n_phase = PH_INDEX;
                    end
                end
                PH_INDEX: begin
                    if (leb_bad || leb_done) begin
                        o_res_valid = 1'b1;
                        n_phase     = PH_IDLE;
                        n_leb       = '0;
                        n_cnt       = '0;
                        if (leb_bad) begin
                            o_res = '{status: leb_bad_code(e_kind), kind: e_kind,
                                      index_value: '0};
                        end else if (leb_val >= limit) begin
                            o_res = '{status: range_code(e_kind), kind: e_kind,
                                      index_value: leb_val};
                        end else begin
                            o_res = '{status: ST_OK, kind: e_kind, index_value: leb_val};
                        end
                    end else begin
                        n_leb = leb_val;
                        n_cnt = e_cnt + 3'd1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_leb      <= '0;
            r_cnt      <= '0;
            r_skip     <= '0;
            r_kind     <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            r_phase    <= n_phase;
            r_leb      <= n_leb;
            r_cnt      <= n_cnt;
            r_skip     <= n_skip;
            r_kind     <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_entry_start;
        end
    end

endmodule

// ----- hdl/eecu_out_reg.sv -----
// Result register: holds one finished result until the sink takes it.
// Depends on eecu_pkg.
module eecu_out_reg
    import eecu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_take_ok,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_take_ok = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_take_ok) begin
            n_valid = i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take_ok && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- hdl/export_entry_checker_unit.sv -----
// Top level of the export entry checker: register block, parser, result register.
// Depends on eecu_pkg, eecu_if, eecu_cfg_regs, eecu_parser, eecu_out_reg.
//
//  port      dir  role                     payload
//  i_byte    in   entry bytes, sink        data_byte[7:0], entry_start
//  o_result  out  at most one per entry    status[3:0], export_kind[1:0], index_value[31:0]
//  APB       in   limit registers          paddr[3:0], pwdata/prdata[31:0]
//
// One byte per cycle when not stalled; the last byte of an entry passes the input register,
// then the entry's result is registered in the result register.
// Synchronous active-low reset clears the parser, limits and both valid flags.
// A stalled result holds in the result register; input stalls only when that register
// is full and not being taken while a byte waits in the input register.
module export_entry_checker_unit
    import eecu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    eecu_byte_if.sink         i_byte,
    eecu_result_if.source     o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_limits limits;
    logic    take_ok;
    logic    res_valid;
    t_result res;
    t_result out_res;

    eecu_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_limits (limits)
    );

    eecu_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_byte.valid),
        .i_data_byte   (i_byte.data_byte),
        .i_entry_start (i_byte.entry_start),
        .o_in_ready    (i_byte.ready),
        .i_take_ok     (take_ok),
        .i_limits      (limits),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    eecu_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_take_ok   (take_ok),
        .o_valid     (o_result.valid),
        .i_ready     (o_result.ready),
        .o_res       (out_res)
    );

    assign o_result.status      = out_res.status;
    assign o_result.export_kind = out_res.kind;
    assign o_result.index_value = out_res.index_value;

endmodule

// ----- hdl/eecu_checker.sv -----
// Port-level checks on the export entry checker's result channel and register port,
// bound to the top level. Depends on eecu_pkg.
module eecu_checker
    import eecu_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                i_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [KIND_W-1:0]   i_kind,
    input logic [DATA_W-1:0]   i_index,
    input logic                i_pready
);

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_kind)
                                && $stable(i_index))
        else $error("stalled result changed");

    a_kind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_NAME_LEB || i_status == ST_BAD_KIND) |-> i_kind == '0)
        else $error("kind not zero for name or kind error");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_NAME_LEB || i_status == ST_BAD_KIND
                    || i_status == ST_FUNC_LEB || i_status == ST_TABLE_LEB
                    || i_status == ST_MEM_LEB || i_status == ST_GLOBAL_LEB)
        |-> i_index == '0)
        else $error("index not zero for error without index");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind export_entry_checker_unit eecu_checker u_eecu_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_result.valid),
    .i_ready  (o_result.ready),
    .i_status (o_result.status),
    .i_kind   (o_result.export_kind),
    .i_index  (o_result.index_value),
    .i_pready (pready)
);

// ----- bench/export_entry_checker_unit_test.sv -----
`timescale 1ns / 100ps
// Testbench for export_entry_checker_unit: streams export entries byte by byte over
// the byte interface and scores every result transfer against a local parser model.
// Depends on eecu_pkg, eecu_if and the RTL of the block.
module export_entry_checker_unit_test;
    import eecu_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned PHASE_BYTES  = 90;
    localparam int unsigned NUM_PHASES   = 5;

    typedef enum logic [2:0] {P_IDLE, P_NAME, P_SKIP, P_KIND, P_INDEX} parse_phase_e;
    typedef enum logic [1:0] {LEB_MORE, LEB_DONE, LEB_BAD} leb_step_e;
    typedef enum int {LIM_SMALL, LIM_ZERO, LIM_FULL, LIM_RANDOM, LIM_MIXED} limit_mode_e;

    class entry_scoreboard;
        t_result      awaited [$];
        logic [31:0]  limit_tab [NUM_REGS];
        parse_phase_e phase;
        logic [31:0]  acc;
        logic [2:0]   leb_count;
        logic [31:0]  skip_left;
        logic [1:0]   kind_q;
        int unsigned  fails;

        function new();
            foreach (limit_tab[i]) limit_tab[i] = '0;
            phase = P_IDLE;
            acc = '0;
            leb_count = '0;
            skip_left = '0;
            kind_q = KIND_FUNC;
            fails = 0;
        endfunction

        function leb_step_e leb_take(logic [7:0] b);
            if (leb_count >= 3'd4) begin
                if (b[7:4] != 4'd0) return LEB_BAD;
                acc[31:28] = acc[31:28] | b[3:0];
                return LEB_DONE;
            end
            acc = acc | ({25'd0, b[6:0]} << (7 * leb_count));
            if (!b[7]) return LEB_DONE;
            leb_count = leb_count + 3'd1;
            return LEB_MORE;
        endfunction

        function void finish_entry(logic [3:0] st, logic [1:0] kd, logic [31:0] ix);
            t_result r;
            r.status = st;
            r.kind = kd;
            r.index_value = ix;
            awaited.push_back(r);
            phase = P_IDLE;
            acc = '0;
            leb_count = '0;
        endfunction

        // one transferred input byte
        function void note_byte(logic [7:0] b, logic start);
            leb_step_e step;
            if (start) begin
                phase = P_NAME;
                acc = '0;
                leb_count = '0;
                skip_left = '0;
                kind_q = KIND_FUNC;
            end
            case (phase)
                P_NAME: begin
                    step = leb_take(b);
                    if (step == LEB_BAD) begin
                        finish_entry(ST_NAME_LEB, KIND_FUNC, '0);
                    end else if (step == LEB_DONE) begin
                        skip_left = acc;
                        acc = '0;
                        leb_count = '0;
                        phase = (skip_left == '0) ? P_KIND : P_SKIP;
                    end
                end
                P_SKIP: begin
                    skip_left = skip_left - 1;
                    if (skip_left == '0) phase = P_KIND;
                end
                P_KIND: begin
                    if (b > 8'd3) begin
                        finish_entry(ST_BAD_KIND, KIND_FUNC, '0);
                    end else begin
                        kind_q = b[1:0];
                        acc = '0;
                        leb_count = '0;
                        phase = P_INDEX;
                    end
                end
                P_INDEX: begin
                    step = leb_take(b);
                    if (step == LEB_BAD) begin
                        finish_entry(ST_FUNC_LEB + {kind_q, 1'b0}, kind_q, '0);
                    end else if (step == LEB_DONE) begin
                        if (acc >= limit_tab[kind_q])
                            finish_entry(ST_FUNC_RANGE + {kind_q, 1'b0}, kind_q, acc);
                        else
                            finish_entry(ST_OK, kind_q, acc);
                    end
                end
                default: phase = P_IDLE;
            endcase
        endfunction

        function void check_result(logic [3:0] st, logic [1:0] kd, logic [31:0] ix);
            t_result want;
            if (awaited.size() == 0) begin
                $error("result transfer with no entry awaiting it: status %0d kind %0d index %0h",
                       st, kd, ix);
                fails++;
                return;
            end
            want = awaited.pop_front();
            if (st !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, st);
                fails++;
            end
            if (kd !== want.kind) begin
                $error("export_kind: expected %0d, actual %0d", want.kind, kd);
                fails++;
            end
            if (ix !== want.index_value) begin
                $error("index_value: expected %0h, actual %0h", want.index_value, ix);
                fails++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic              idle_enable;
    logic              hold_go;
    logic              long_hold;
    int unsigned       sink_wait = 0;
    bit                sink_calm = 1'b0;
    int unsigned       cycle_count = 0;

    logic [8:0]        stream_q [$];   // {entry_start, data_byte}
    entry_scoreboard   sb;

    eecu_byte_if   byte_bus ();
    eecu_result_if res_bus ();

    export_entry_checker_unit u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_byte   (byte_bus),
        .o_result (res_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, sb.awaited.size());
            $display("export_entry_checker_unit_test NOT OK");
            $finish;
        end
    end

    // result side: random stall bursts, calm stretches, and the long hold
    always @(posedge clk) begin
        if ($urandom_range(0, 149) == 0) sink_calm <= !sink_calm;
        if (long_hold) begin
            res_bus.ready <= 1'b0;
        end else if (sink_wait != 0) begin
            res_bus.ready <= 1'b0;
            sink_wait <= sink_wait - 1;
        end else if (idle_enable && !sink_calm && $urandom_range(0, 5) == 0) begin
            res_bus.ready <= 1'b0;
            sink_wait <= $urandom_range(0, 12);
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    initial begin : long_hold_proc
        long_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && res_bus.valid && res_bus.ready)
            sb.check_result(res_bus.status, res_bus.export_kind, res_bus.index_value);
    end

    function automatic void put_byte(logic [7:0] b);
        stream_q.push_back({1'b0, b});
    endfunction

    function automatic void put_start_byte(logic [7:0] b);
        stream_q.push_back({1'b1, b});
    endfunction

    function automatic int unsigned pad_extra();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    endfunction

    // LEB128, optionally padded with redundant continuation bytes (five at most)
    function automatic void put_leb(logic [31:0] v, int unsigned extra);
        int unsigned n;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 0) n++;
        n = (n + extra > 5) ? 5 : n + extra;
        for (int unsigned i = 0; i < n; i++)
            put_byte({(i < n - 1) ? 1'b1 : 1'b0, 7'(v >> (7 * i))});
    endfunction

    // five bytes: either the fifth still continues or it carries excess bits
    function automatic void put_bad_leb();
        repeat (4) put_byte(8'h80 | 8'($urandom));
        if ($urandom_range(0, 1) == 0)
            put_byte(8'h80 | 8'($urandom));
        else
            put_byte({1'b0, 3'($urandom_range(1, 7)), 4'($urandom)});
    endfunction

    function automatic void put_name();
        int unsigned name_len;
        name_len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
        put_leb(name_len, pad_extra());
        repeat (name_len) put_byte(8'($urandom));
    endfunction

    function automatic void put_good_entry();
        logic [1:0]  kd;
        logic [31:0] lim;
        logic [31:0] idx;
        kd = 2'($urandom_range(0, 3));
        lim = sb.limit_tab[kd];
        case ($urandom_range(0, 6))
            0:       idx = '0;
            1:       idx = lim - 1;
            2:       idx = lim;
            3:       idx = lim + 1;
            4:       idx = $urandom;
            5:       idx = $urandom_range(0, 127);
            default: idx = '1;
        endcase
        put_name();
        put_byte({6'd0, kd});
        put_leb(idx, pad_extra());
    endfunction

    function automatic void put_random_entry();
        int unsigned first;
        int unsigned pick;
        int unsigned cut;
        first = stream_q.size();
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            // stray bytes with no start mark
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
            return;
        end
        if (pick < 72) begin
            put_good_entry();
        end else if (pick < 80) begin
            put_bad_leb();
        end else if (pick < 87) begin
            put_name();
            put_byte(8'($urandom_range(4, 255)));
        end else if (pick < 94) begin
            put_name();
            put_byte({6'd0, 2'($urandom_range(0, 3))});
            put_bad_leb();
        end else begin
            // cut short, so the next start mark lands mid entry
            put_good_entry();
            cut = $urandom_range(1, stream_q.size() - first - 1);
            repeat (cut) void'(stream_q.pop_back());
        end
        stream_q[first][8] = 1'b1;
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
    endfunction

    task automatic drive_stream();
        logic [8:0]  item;
        int unsigned src_left = 0;
        bit          src_gappy = 1'b0;
        while (stream_q.size() != 0) begin
            item = stream_q.pop_front();
            if (src_left == 0) begin
                src_gappy = bit'($urandom_range(0, 1));
                src_left = $urandom_range(10, 60);
            end
            src_left--;
            if (idle_enable && src_gappy && $urandom_range(0, 3) == 0) begin
                byte_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            byte_bus.valid <= 1'b1;
            byte_bus.data_byte <= item[7:0];
            byte_bus.entry_start <= item[8];
            do @(posedge clk); while (!byte_bus.ready);
            sb.note_byte(item[7:0], item[8]);
        end
        byte_bus.valid <= 1'b0;
    endtask

    task automatic write_limits(input logic [31:0] vals [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= ADDR_W'(4 * i);
            pwdata <= vals[i];
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            sb.limit_tab[i] = vals[i];
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drain();
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin : main_flow
        logic [31:0] lim_vals [NUM_REGS];
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        byte_bus.valid = 1'b0;
        byte_bus.data_byte = '0;
        byte_bus.entry_start = 1'b0;
        res_bus.ready = 1'b0;
        idle_enable = 1'b1;
        hold_go = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // limits still at reset: table index 0 is out of range
        put_start_byte(8'h00);
        put_byte({6'd0, KIND_TABLE});
        put_byte(8'h00);
        drive_stream();
        wait_drain();

        lim_vals[REG_FUNC_LIMIT] = 32'd1;
        lim_vals[REG_TABLE_LIMIT] = 32'd0;
        lim_vals[REG_MEM_LIMIT] = 32'hFFFF_FFFF;
        lim_vals[REG_GLOBAL_LIMIT] = 32'h8000_0000;
        write_limits(lim_vals);

        put_byte(8'hFF);                            // idle, no start mark
        put_start_byte(8'h05);                      // dropped by the next start
        put_byte(8'h41);
        put_start_byte(8'h00);                      // empty name, function 0
        put_byte({6'd0, KIND_FUNC});
        put_byte(8'h00);
        put_start_byte(8'h01);                      // global index all ones
        put_byte(8'hAA);
        put_byte({6'd0, KIND_GLOBAL});
        put_byte(8'hFF);
        put_byte(8'hFF);
        put_byte(8'hFF);
        put_byte(8'hFF);
        put_byte(8'h0F);
        put_start_byte(8'h00);                      // unknown kind, then ignored byte
        put_byte(8'h04);
        put_byte(8'h7F);
        put_start_byte(8'h80);                      // name length runs past five bytes
        put_byte(8'h80);
        put_byte(8'h80);
        put_byte(8'h80);
        put_byte(8'h80);
        put_start_byte(8'h00);                      // memory index with excess bits
        put_byte({6'd0, KIND_MEM});
        put_byte(8'h80);
        put_byte(8'h80);
        put_byte(8'h80);
        put_byte(8'h80);
        put_byte(8'h10);
        drive_stream();
        wait_drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                case (limit_mode_e'(ph))
                    LIM_SMALL:  lim_vals[r] = $urandom_range(0, 20);
                    LIM_ZERO:   lim_vals[r] = '0;
                    LIM_FULL:   lim_vals[r] = '1;
                    LIM_RANDOM: lim_vals[r] = $urandom;
                    default: begin
                        case ($urandom_range(0, 3))
                            0:       lim_vals[r] = '0;
                            1:       lim_vals[r] = 32'd1;
                            2:       lim_vals[r] = '1;
                            default: lim_vals[r] = $urandom;
                        endcase
                    end
                endcase
            end
            write_limits(lim_vals);
            if (ph == 1) hold_go <= 1'b1;
            if (ph == NUM_PHASES - 1) idle_enable <= 1'b0;
            while (stream_q.size() < PHASE_BYTES) put_random_entry();
            drive_stream();
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fails == 0 && sb.awaited.size() == 0) begin
            $display("export_entry_checker_unit_test OK");
        end else begin
            $display("export_entry_checker_unit_test NOT OK");
        end
        $finish;
    end

endmodule
